@@ rtl/core/bbvp_pkg.sv @@
package bbvp_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 48;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W        = 64;
  localparam int SIZE_W        = 16;
  localparam int ICNT_W        = 64;
  localparam int IVAL_W        = 32;
  localparam int OCNT_W        = 48;
  localparam int ENT_W         = ADDR_W + COUNT_BITS;
  localparam int BIT_W         = $clog2(ICNT_W);
  localparam logic [31:0] IVAL_RESET = 32'd100000000;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_BOUNDARY = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] target_address;
    logic [SIZE_W-1:0] block_size;
    logic [ICNT_W-1:0] instr_count;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_address;
    logic [OCNT_W-1:0] entry_count;
    logic              entry_valid;
    logic              overflow;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_INS_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_REM,
    ST_REM_CHK,
    ST_MARK,
    ST_DMP_RD,
    ST_DMP_LD,
    ST_OUT_WT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic rd_pos;
    logic rd_kprev;
    logic pos_inc;
    logic k_init;
    logic k_dec;
    logic write_shift;
    logic write_new;
    logic write_acc;
    logic set_ovf;
    logic rem_step;
    logic load_entry;
    logic load_marker;
    logic dump_clear;
  } cmd_t;

  typedef struct packed {
    logic used_zero;
    logic full;
    logic pos_end;
    logic k_eq_pos;
    logic cmp_eq;
    logic cmp_lt;
    logic rem_last;
    logic rem_zero;
    logic ival_zero;
    logic out_taken;
    logic out_last;
  } status_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [SIZE_W-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/bbvp_ram.sv @@
module bbvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/bbvp_ctrl.sv @@
module bbvp_ctrl
  import bbvp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_BOUNDARY) ? ST_REM : ST_SRCH;
        end
      end
      ST_SRCH:    state_nxt = sts.pos_end ? ST_INS_CHK : ST_CMP;
      ST_CMP: begin
        if (sts.cmp_eq) state_nxt = ST_IDLE;
        else if (sts.cmp_lt) state_nxt = ST_SRCH;
        else state_nxt = ST_INS_CHK;
      end
      ST_INS_CHK: state_nxt = sts.full ? ST_IDLE : ST_SH_RD;
      ST_SH_RD:   state_nxt = sts.k_eq_pos ? ST_IDLE : ST_SH_WR;
      ST_SH_WR:   state_nxt = ST_SH_RD;
      ST_REM: begin
        if (sts.ival_zero) state_nxt = ST_IDLE;
        else if (sts.rem_last) state_nxt = ST_REM_CHK;
      end
      ST_REM_CHK: begin
        if (!sts.rem_zero) state_nxt = ST_IDLE;
        else if (sts.used_zero) state_nxt = ST_MARK;
        else state_nxt = ST_DMP_RD;
      end
      ST_MARK:    state_nxt = ST_OUT_WT;
      ST_DMP_RD:  state_nxt = ST_DMP_LD;
      ST_DMP_LD:  state_nxt = ST_OUT_WT;
      ST_OUT_WT: begin
        if (sts.out_taken) state_nxt = sts.out_last ? ST_IDLE : ST_DMP_RD;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:    cmd.latch_in = in_valid;
      ST_SRCH:    cmd.rd_pos = !sts.pos_end;
      ST_CMP: begin
        cmd.write_acc = sts.cmp_eq;
        cmd.pos_inc   = !sts.cmp_eq && sts.cmp_lt;
      end
      ST_INS_CHK: begin
        cmd.set_ovf = sts.full;
        cmd.k_init  = !sts.full;
      end
      ST_SH_RD: begin
        cmd.write_new = sts.k_eq_pos;
        cmd.rd_kprev  = !sts.k_eq_pos;
      end
      ST_SH_WR: begin
        cmd.write_shift = 1'b1;
        cmd.k_dec       = 1'b1;
      end
      ST_REM:     cmd.rem_step = !sts.ival_zero;
      ST_REM_CHK: ;
      ST_MARK:    cmd.load_marker = 1'b1;
      ST_DMP_RD:  cmd.rd_pos = 1'b1;
      ST_DMP_LD:  cmd.load_entry = 1'b1;
      ST_OUT_WT: begin
        cmd.dump_clear = sts.out_taken && sts.out_last;
        cmd.pos_inc    = sts.out_taken && !sts.out_last;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/bbvp_dp.sv @@
module bbvp_dp
  import bbvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [IVAL_W-1:0] cfg_wdata,
  input  cmd_t              cmd,
  output status_t           sts,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  logic [IVAL_W-1:0]     ival_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [SIZE_W-1:0]     size_r;
  logic [ICNT_W-1:0]     icnt_r, icnt_nxt;
  logic [IVAL_W-1:0]     rem_r, rem_nxt;
  logic [BIT_W-1:0]      bit_r;
  logic [USED_W-1:0]     pos_r, used_r;
  logic [IDX_W-1:0]      k_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  out_item_t             out_r;
  logic [IVAL_W:0]       rem_sh;
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [ENT_W-1:0]      wr_data, rd_data;
  logic [ADDR_W-1:0]     rd_ent_addr;
  logic [COUNT_BITS-1:0] rd_ent_cnt;

  assign rd_ent_addr = rd_data[ENT_W-1:COUNT_BITS];
  assign rd_ent_cnt  = rd_data[COUNT_BITS-1:0];

  // one restoring step of the remainder per cycle, MSB first
  always_comb begin
    rem_sh   = {rem_r, icnt_r[ICNT_W-1]};
    rem_nxt  = (rem_sh >= {1'b0, ival_r}) ? IVAL_W'(rem_sh - {1'b0, ival_r})
                                          : rem_sh[IVAL_W-1:0];
    icnt_nxt = {icnt_r[ICNT_W-2:0], 1'b0};
  end

  always_comb begin
    wr_en   = cmd.write_acc || cmd.write_new || cmd.write_shift;
    wr_addr = cmd.write_shift ? k_r : pos_r[IDX_W-1:0];
    if (cmd.write_acc) begin
      wr_data = {addr_r, sat_add(rd_ent_cnt, size_r)};
    end else if (cmd.write_new) begin
      wr_data = {addr_r, sat_add('0, size_r)};
    end else begin
      wr_data = rd_data;
    end
    rd_en   = cmd.rd_pos || cmd.rd_kprev;
    rd_addr = cmd.rd_kprev ? IDX_W'(k_r - 1'b1) : pos_r[IDX_W-1:0];
  end

  bbvp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ival_r      <= IVAL_RESET;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ival_r <= cfg_wdata;
      if (cmd.write_new) used_r <= used_r + 1'b1;
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.dump_clear) begin
        used_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.load_entry || cmd.load_marker) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      addr_r <= in_data.target_address;
      size_r <= in_data.block_size;
      icnt_r <= in_data.instr_count;
      rem_r  <= '0;
      bit_r  <= '0;
      pos_r  <= '0;
    end else begin
      if (cmd.pos_inc) pos_r <= pos_r + 1'b1;
      if (cmd.rem_step) begin
        rem_r  <= rem_nxt;
        icnt_r <= icnt_nxt;
        bit_r  <= bit_r + 1'b1;
      end
    end
    if (cmd.k_init) k_r <= used_r[IDX_W-1:0];
    else if (cmd.k_dec) k_r <= k_r - 1'b1;
    if (cmd.load_entry) begin
      out_r.entry_address <= rd_ent_addr;
      out_r.entry_count   <= OCNT_W'(rd_ent_cnt);
      out_r.entry_valid   <= 1'b1;
      out_r.overflow      <= ovf_r;
      out_r.last          <= (pos_r + 1'b1 == used_r);
    end else if (cmd.load_marker) begin
      out_r.entry_address <= '0;
      out_r.entry_count   <= '0;
      out_r.entry_valid   <= 1'b0;
      out_r.overflow      <= ovf_r;
      out_r.last          <= 1'b1;
    end
  end

  always_comb begin
    sts.used_zero = (used_r == '0);
    sts.full      = (used_r == USED_W'(TABLE_ENTRIES));
    sts.pos_end   = (pos_r == used_r);
    sts.k_eq_pos  = (USED_W'(k_r) == pos_r);
    sts.cmp_eq    = (rd_ent_addr == addr_r);
    sts.cmp_lt    = (rd_ent_addr < addr_r);
    sts.rem_last  = (bit_r == {BIT_W{1'b1}});
    sts.rem_zero  = (rem_r == '0);
    sts.ival_zero = (ival_r == '0);
    sts.out_taken = out_valid_r && !out_stall;
    sts.out_last  = out_r.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_ENTRIES))
    else $error("table fill beyond capacity");
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_entry || cmd.load_marker) |-> !out_valid_r)
    else $error("output register overwritten");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_new |-> !sts.full)
    else $error("insert into full table");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_clear |=> (used_r == '0) && !ovf_r)
    else $error("table not cleared after dump");
`endif

endmodule

@@ rtl/core/basic_block_vector_profiler_unit.sv @@
// Add: reads and compares the sorted table entry by entry from the start; a match
//   adds block_size to its saturating count; else it is inserted (overflow if full).
// Boundary: serial remainder of instr_count by interval_length; if it is zero, each
//   entry is read, loaded and held until the output takes it, then the table clears.
// One item at a time; the input is stalled until the item is finished.
// Synchronous active-low reset empties the table, clears overflow, sets interval to 1e8.
module basic_block_vector_profiler_unit
  import bbvp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [IVAL_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t sts;

  bbvp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bbvp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
